// ----- rtl/ray_parallelogram_closest_hit_top_macros.svh -----
// Assertion helpers of the closest-hit block, used by its evaluation sequencer.
// They sample on clk_i and are off while rst_ni is low.
`ifndef RAY_PARALLELOGRAM_CLOSEST_HIT_TOP_MACROS_SVH
`define RAY_PARALLELOGRAM_CLOSEST_HIT_TOP_MACROS_SVH

`define RPCH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

`define RPCH_ASSERT_IMP(lbl, ante, cons, msg) \
  `RPCH_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ----- rtl/rpch_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpch_pkg
// Types and constants of the ray / parallelogram closest-hit block.
// ----------------------------------------------------------------------------
package rpch_pkg;

  localparam int unsigned CoordW  = 32;
  localparam int unsigned IdW     = 32;
  localparam int unsigned TqW     = 16;
  localparam int unsigned BestW   = TqW + 1;
  // Serial multiplier: A operand holds num/den, B operand holds the edge dots.
  localparam int unsigned AW      = 3 * CoordW + 6;
  localparam int unsigned BW      = 2 * CoordW + 4;
  localparam int unsigned AccW    = AW + BW;
  localparam int unsigned MulCntW = $clog2(BW);
  localparam int unsigned DivCntW = $clog2(TqW);

  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CfgOriginX = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgOriginY = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgOriginZ = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgDirX    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgDirY    = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgDirZ    = 3'd5;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [BestW-1:0] TOne = BestW'(1) << TqW;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [CoordW:0] x;
    logic signed [CoordW:0] y;
    logic signed [CoordW:0] z;
  } wvec_t;

  typedef struct packed {
    logic [IdW-1:0]           patch_id;
    logic signed [CoordW-1:0] anchor_x;
    logic signed [CoordW-1:0] anchor_y;
    logic signed [CoordW-1:0] anchor_z;
    logic signed [CoordW-1:0] edge1_x;
    logic signed [CoordW-1:0] edge1_y;
    logic signed [CoordW-1:0] edge1_z;
    logic signed [CoordW-1:0] edge2_x;
    logic signed [CoordW-1:0] edge2_y;
    logic signed [CoordW-1:0] edge2_z;
    logic                     last_patch;
  } in_t;

  typedef struct packed {
    logic             hit_found;
    logic [IdW-1:0]   hit_id;
    logic [BestW-1:0] nearest_t;
  } out_t;

  // Queue entry: anchor already moved into the ray's frame.
  typedef struct packed {
    logic [IdW-1:0] patch_id;
    wvec_t          w;
    vec_t           e1;
    vec_t           e2;
    logic           last;
  } qent_t;

endpackage

// ----- rtl/rpch_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpch_front
// Ray registers and patch intake; forms anchor minus origin and queues it.
// ----------------------------------------------------------------------------
module rpch_front import rpch_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_t                in_data_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CoordW-1:0]  cfg_data_i,
  input  logic               q_full_i,
  output logic               push_o,
  output qent_t              push_data_o,
  output vec_t               dir_o
);

  vec_t origin_q;
  vec_t dir_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_q <= '0;
      dir_q    <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgOriginX: origin_q.x <= cfg_data_i;
        CfgOriginY: origin_q.y <= cfg_data_i;
        CfgOriginZ: origin_q.z <= cfg_data_i;
        CfgDirX:    dir_q.x    <= cfg_data_i;
        CfgDirY:    dir_q.y    <= cfg_data_i;
        CfgDirZ:    dir_q.z    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;
  assign dir_o      = dir_q;

  always_comb begin
    push_data_o.patch_id = in_data_i.patch_id;
    push_data_o.w.x = (CoordW+1)'($signed(in_data_i.anchor_x))
                      - (CoordW+1)'($signed(origin_q.x));
    push_data_o.w.y = (CoordW+1)'($signed(in_data_i.anchor_y))
                      - (CoordW+1)'($signed(origin_q.y));
    push_data_o.w.z = (CoordW+1)'($signed(in_data_i.anchor_z))
                      - (CoordW+1)'($signed(origin_q.z));
    push_data_o.e1.x = in_data_i.edge1_x;
    push_data_o.e1.y = in_data_i.edge1_y;
    push_data_o.e1.z = in_data_i.edge1_z;
    push_data_o.e2.x = in_data_i.edge2_x;
    push_data_o.e2.y = in_data_i.edge2_y;
    push_data_o.e2.z = in_data_i.edge2_z;
    push_data_o.last = in_data_i.last_patch;
  end

endmodule

// ----- rtl/rpch_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpch_fifo
// Short patch queue between the intake and the evaluation sequencer.
// ----------------------------------------------------------------------------
module rpch_fifo import rpch_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  qent_t push_data_i,
  input  logic  pop_i,
  output qent_t q_data_o,
  output logic  full_o,
  output logic  empty_o
);

  qent_t             mem_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]  cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign q_data_o = mem_q[rd_ptr_q];
  assign full_o   = (cnt_q == QCntW'(QDepth));
  assign empty_o  = (cnt_q == '0);

endmodule

// ----- rtl/rpch_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpch_mul
// Signed shift-and-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module rpch_mul import rpch_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [AW-1:0]   a_i,
  input  logic signed [BW-1:0]   b_i,
  output logic                   done_o,
  output logic signed [AccW-1:0] p_o
);

  logic               run_q, done_q;
  logic [MulCntW-1:0] cnt_q;
  logic               neg_q;
  logic [AccW-1:0]    areg_q, acc_q;
  logic [BW-1:0]      breg_q;
  logic [AW-1:0]      a_mag;
  logic [BW-1:0]      b_mag;

  // Magnitudes are taken as unsigned so the most negative code still works.
  assign a_mag = a_i[AW-1] ? AW'(-a_i) : AW'(a_i);
  assign b_mag = b_i[BW-1] ? BW'(-b_i) : BW'(b_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == MulCntW'(BW - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      areg_q <= AccW'(a_mag);
      breg_q <= b_mag;
      acc_q  <= '0;
      neg_q  <= a_i[AW-1] ^ b_i[BW-1];
    end else if (run_q) begin
      if (breg_q[0]) begin
        acc_q <= acc_q + areg_q;
      end
      areg_q <= areg_q << 1;
      breg_q <= breg_q >> 1;
    end
  end

  assign done_o = done_q;
  assign p_o    = neg_q ? -$signed(acc_q) : $signed(acc_q);

endmodule

// ----- rtl/rpch_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpch_back
// Evaluation sequencer: normal, ray parameter, edge tests, nearest-hit state.
// ----------------------------------------------------------------------------
`include "ray_parallelogram_closest_hit_top_macros.svh"

module rpch_back import rpch_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  q_empty_i,
  input  qent_t q_data_i,
  output logic  q_pop_o,
  input  vec_t  dir_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output out_t  out_data_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MSTART = 3'd1;
  localparam logic [2:0] ST_MWAIT  = 3'd2;
  localparam logic [2:0] ST_CLASS  = 3'd3;
  localparam logic [2:0] ST_DIV    = 3'd4;
  localparam logic [2:0] ST_TCMP   = 3'd5;
  localparam logic [2:0] ST_EDGE   = 3'd6;
  localparam logic [2:0] ST_FINISH = 3'd7;

  localparam logic [3:0] DstNone = 4'd0;
  localparam logic [3:0] DstN0   = 4'd1;
  localparam logic [3:0] DstN1   = 4'd2;
  localparam logic [3:0] DstN2   = 4'd3;
  localparam logic [3:0] DstNum  = 4'd4;
  localparam logic [3:0] DstDen  = 4'd5;
  localparam logic [3:0] DstEd   = 4'd6;
  localparam logic [3:0] DstEw   = 4'd7;
  localparam logic [3:0] DstEe   = 4'd8;
  localparam logic [3:0] DstQ    = 4'd9;
  localparam logic [3:0] DstLim  = 4'd10;

  localparam logic [4:0] StepDen     = 5'd11;
  localparam logic [4:0] StepEdge    = 5'd12;
  localparam logic [4:0] StepLastEdg = 5'd23;

  function automatic logic signed [AW-1:0] a_c(logic signed [CoordW-1:0] v);
    return AW'(v);
  endfunction
  function automatic logic signed [AW-1:0] a_r(logic signed [AccW-1:0] v);
    return AW'(v);
  endfunction
  function automatic logic signed [BW-1:0] b_c(logic signed [CoordW-1:0] v);
    return BW'(v);
  endfunction
  function automatic logic signed [BW-1:0] b_w(logic signed [CoordW:0] v);
    return BW'(v);
  endfunction
  function automatic logic signed [BW-1:0] b_r(logic signed [AccW-1:0] v);
    return BW'(v);
  endfunction

  logic [2:0]         state_q, state_d;
  logic [4:0]         step_q, step_d;
  logic               edge_q, edge_d;
  logic               hit_q, hit_d;
  logic [DivCntW-1:0] div_cnt_q, div_cnt_d;
  logic [BestW-1:0]   best_t_q, best_t_d;
  logic [IdW-1:0]     best_id_q, best_id_d;
  logic               any_q, any_d;
  logic               out_valid_q, out_valid_d;
  out_t               out_data_q;

  logic signed [AccW-1:0] acc_q, n0_q, n1_q, n2_q, num_q, den_q;
  logic signed [AccW-1:0] ed_q, ew_q, ee_q, qv_q, lim_q;
  logic [AW-1:0]          ad_q, rem_q;
  logic [TqW-1:0]         tq_q;

  logic                   mul_start, mul_done;
  logic signed [AccW-1:0] mul_p;
  logic signed [AW-1:0]   op_a;
  logic signed [BW-1:0]   op_b;
  logic                   op_neg, op_first;
  logic [3:0]             op_dst;
  logic signed [AccW-1:0] acc_sum;
  vec_t                   ev;

  logic                   num_neg, den_neg, cls_ok;
  logic [AccW-1:0]        an_full, ad_full;
  logic [AW-1:0]          rem2;
  logic                   div_ge;
  logic signed [AccW-1:0] qq;
  logic                   edge_ok, fin_go, out_load;
  out_t                   res;

  rpch_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (op_a),
    .b_i     (op_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  assign ev = edge_q ? q_data_i.e2 : q_data_i.e1;

  // Multiply-accumulate program; each term ends the dot product it closes.
  always_comb begin
    op_a = '0;
    op_b = '0;
    op_neg = 1'b0;
    op_first = 1'b0;
    op_dst = DstNone;
    unique case (step_q)
      5'd0: begin op_a = a_c(q_data_i.e1.y); op_b = b_c(q_data_i.e2.z); op_first = 1'b1; end
      5'd1: begin op_a = a_c(q_data_i.e1.z); op_b = b_c(q_data_i.e2.y); op_neg = 1'b1;
              op_dst = DstN0; end
      5'd2: begin op_a = a_c(q_data_i.e1.z); op_b = b_c(q_data_i.e2.x); op_first = 1'b1; end
      5'd3: begin op_a = a_c(q_data_i.e1.x); op_b = b_c(q_data_i.e2.z); op_neg = 1'b1;
              op_dst = DstN1; end
      5'd4: begin op_a = a_c(q_data_i.e1.x); op_b = b_c(q_data_i.e2.y); op_first = 1'b1; end
      5'd5: begin op_a = a_c(q_data_i.e1.y); op_b = b_c(q_data_i.e2.x); op_neg = 1'b1;
              op_dst = DstN2; end
      5'd6: begin op_a = a_r(n0_q); op_b = b_w(q_data_i.w.x); op_first = 1'b1; end
      5'd7: begin op_a = a_r(n1_q); op_b = b_w(q_data_i.w.y); end
      5'd8: begin op_a = a_r(n2_q); op_b = b_w(q_data_i.w.z); op_dst = DstNum; end
      5'd9: begin op_a = a_r(n0_q); op_b = b_c(dir_i.x); op_first = 1'b1; end
      5'd10: begin op_a = a_r(n1_q); op_b = b_c(dir_i.y); end
      5'd11: begin op_a = a_r(n2_q); op_b = b_c(dir_i.z); op_dst = DstDen; end
      5'd12: begin op_a = a_c(ev.x); op_b = b_c(dir_i.x); op_first = 1'b1; end
      5'd13: begin op_a = a_c(ev.y); op_b = b_c(dir_i.y); end
      5'd14: begin op_a = a_c(ev.z); op_b = b_c(dir_i.z); op_dst = DstEd; end
      5'd15: begin op_a = a_c(ev.x); op_b = b_w(q_data_i.w.x); op_first = 1'b1; end
      5'd16: begin op_a = a_c(ev.y); op_b = b_w(q_data_i.w.y); end
      5'd17: begin op_a = a_c(ev.z); op_b = b_w(q_data_i.w.z); op_dst = DstEw; end
      5'd18: begin op_a = a_c(ev.x); op_b = b_c(ev.x); op_first = 1'b1; end
      5'd19: begin op_a = a_c(ev.y); op_b = b_c(ev.y); end
      5'd20: begin op_a = a_c(ev.z); op_b = b_c(ev.z); op_dst = DstEe; end
      5'd21: begin op_a = a_r(num_q); op_b = b_r(ed_q); op_first = 1'b1; end
      5'd22: begin op_a = a_r(den_q); op_b = b_r(ew_q); op_neg = 1'b1; op_dst = DstQ; end
      5'd23: begin op_a = $signed(ad_q); op_b = b_r(ee_q); op_first = 1'b1;
               op_dst = DstLim; end
      default: ;
    endcase
  end

  assign acc_sum = (op_first ? '0 : acc_q) + (op_neg ? -mul_p : mul_p);

  // Ray parameter classification and the long division of |num| by |den|.
  assign num_neg = num_q[AccW-1];
  assign den_neg = den_q[AccW-1];
  assign an_full = num_neg ? AccW'(-num_q) : AccW'(num_q);
  assign ad_full = den_neg ? AccW'(-den_q) : AccW'(den_q);
  assign cls_ok  = (den_q != '0) && (num_q != '0) && (num_neg == den_neg)
                   && (an_full < ad_full);
  assign rem2    = {rem_q[AW-2:0], 1'b0};
  assign div_ge  = (rem2 >= ad_q);

  assign qq      = den_neg ? -qv_q : qv_q;
  assign edge_ok = !qq[AccW-1] && (qq <= lim_q);

  assign fin_go   = (state_q == ST_FINISH) && (!q_data_i.last || !out_valid_q || out_ready_i);
  assign out_load = fin_go && q_data_i.last;
  assign q_pop_o  = fin_go;

  always_comb begin
    res.hit_found = any_q || hit_q;
    res.hit_id    = hit_q ? q_data_i.patch_id : best_id_q;
    res.nearest_t = hit_q ? {1'b0, tq_q} : best_t_q;
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    edge_d      = edge_q;
    hit_d       = hit_q;
    div_cnt_d   = div_cnt_q;
    best_t_d    = best_t_q;
    best_id_d   = best_id_q;
    any_d       = any_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mul_start   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          step_d  = '0;
          edge_d  = 1'b0;
          hit_d   = 1'b0;
          state_d = ST_MSTART;
        end
      end
      ST_MSTART: begin
        mul_start = 1'b1;
        state_d   = ST_MWAIT;
      end
      ST_MWAIT: begin
        if (mul_done) begin
          if (step_q == StepDen) begin
            state_d = ST_CLASS;
          end else if (step_q == StepLastEdg) begin
            state_d = ST_EDGE;
          end else begin
            step_d  = step_q + 1'b1;
            state_d = ST_MSTART;
          end
        end
      end
      ST_CLASS: begin
        div_cnt_d = '0;
        state_d   = cls_ok ? ST_DIV : ST_FINISH;
      end
      ST_DIV: begin
        div_cnt_d = div_cnt_q + 1'b1;
        if (div_cnt_q == DivCntW'(TqW - 1)) begin
          state_d = ST_TCMP;
        end
      end
      ST_TCMP: begin
        if ({1'b0, tq_q} < best_t_q) begin
          step_d  = StepEdge;
          state_d = ST_MSTART;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_EDGE: begin
        if (!edge_ok) begin
          state_d = ST_FINISH;
        end else if (!edge_q) begin
          edge_d  = 1'b1;
          step_d  = StepEdge;
          state_d = ST_MSTART;
        end else begin
          hit_d   = 1'b1;
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (fin_go) begin
          state_d = ST_IDLE;
          if (q_data_i.last) begin
            out_valid_d = 1'b1;
            best_t_d    = TOne;
            best_id_d   = '0;
            any_d       = 1'b0;
          end else if (hit_q) begin
            best_t_d  = {1'b0, tq_q};
            best_id_d = q_data_i.patch_id;
            any_d     = 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      edge_q      <= 1'b0;
      hit_q       <= 1'b0;
      div_cnt_q   <= '0;
      best_t_q    <= TOne;
      best_id_q   <= '0;
      any_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      edge_q      <= edge_d;
      hit_q       <= hit_d;
      div_cnt_q   <= div_cnt_d;
      best_t_q    <= best_t_d;
      best_id_q   <= best_id_d;
      any_q       <= any_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_MWAIT) && mul_done) begin
      acc_q <= acc_sum;
      unique case (op_dst)
        DstN0:  n0_q  <= acc_sum;
        DstN1:  n1_q  <= acc_sum;
        DstN2:  n2_q  <= acc_sum;
        DstNum: num_q <= acc_sum;
        DstDen: den_q <= acc_sum;
        DstEd:  ed_q  <= acc_sum;
        DstEw:  ew_q  <= acc_sum;
        DstEe:  ee_q  <= acc_sum;
        DstQ:   qv_q  <= acc_sum;
        DstLim: lim_q <= acc_sum;
        default: ;
      endcase
    end
    if (state_q == ST_CLASS) begin
      ad_q  <= AW'(ad_full);
      rem_q <= AW'(an_full);
      tq_q  <= '0;
    end
    if (state_q == ST_DIV) begin
      rem_q <= div_ge ? rem2 - ad_q : rem2;
      tq_q  <= {tq_q[TqW-2:0], div_ge};
    end
    if (out_load) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `RPCH_ASSERT_IMP(a_mul_done_in_wait, mul_done, state_q == ST_MWAIT,
                   "multiplier finished outside the wait state")
  `RPCH_ASSERT_IMP(a_result_from_finish, $rose(out_valid_q),
                   $past(state_q) == ST_FINISH && $past(q_data_i.last),
                   "result raised without a last patch finishing")
  `RPCH_ASSERT_IMP(a_best_below_one, any_q, best_t_q < TOne,
                   "stored hit has a ray parameter of one or more")
  `RPCH_ASSERT_IMP(a_div_nonzero, state_q == ST_DIV, ad_q != '0,
                   "division entered with a zero denominator")

endmodule

// ----- rtl/ray_parallelogram_closest_hit_top.sv -----
`timescale 1ns / 1ps
// Evaluation time is set by the serial multiplier, which runs up to 36 products
// per patch, plus the long division of the ray parameter; a patch that fails
// the ray-parameter test stops before the edge tests. Throughput is one patch
// per evaluation; the two-entry queue lets the source run ahead. Reset clears
// ray registers to zero and the nearest-hit state to "no hit"; no clearing
// pass is needed.
// ----------------------------------------------------------------------------
// ray_parallelogram_closest_hit_top
// Nearest parallelogram hit along one configured ray over a stream of patches.
// ----------------------------------------------------------------------------
module ray_parallelogram_closest_hit_top import rpch_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_t                in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_t               out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CoordW-1:0]  cfg_data_i
);

  logic  q_full, q_empty, push, pop;
  qent_t push_data, q_data;
  vec_t  dir;

  rpch_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data),
    .dir_o       (dir)
  );

  rpch_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .q_data_o    (q_data),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  rpch_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (q_data),
    .q_pop_o     (pop),
    .dir_i       (dir),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
